// File: hdl/rrsc_pkg.sv
// ----------------------------------------------------------------------------
// rrsc_pkg
// Shared types, widths and constants of the quad-quad separating-axis core.
// ----------------------------------------------------------------------------
package rrsc_pkg;

  localparam int COORD_W      = 32;  // Q16.16 coordinate
  localparam int NORM_W       = 16;  // Q2.14 normal component
  localparam int TOL_W        = 16;  // tie tolerance register
  localparam int DEPTH_W      = 31;  // reported overlap
  localparam int PROD_W       = COORD_W + NORM_W;      // one projection term
  localparam int PROJ_W       = PROD_W + 1;            // projection, Q19.30
  localparam int OV_W         = PROJ_W + 1;            // overlap
  localparam int NORMAL_FRAC  = 14;
  localparam int DIFF_W       = COORD_W + 1;           // point difference
  localparam int RED_W        = COORD_W - 1;           // reduced difference
  localparam int SQ_W         = 2 * RED_W;             // product of two reduced
  localparam int DP_W         = SQ_W + 1;              // dot product
  localparam int DEN_W        = 46;                    // divisor bound 2^46
  localparam int T_W          = 16;                    // edge parameter
  localparam int CM_W         = DIFF_W + T_W + 1;      // edge times parameter
  localparam int DIST_W       = 64;                    // squared distance
  localparam int DEF_CORNERS  = 4;
  localparam int DEF_FRACTION_BITS = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
  } nrm_t;

  typedef struct packed {
    logic                   sep;
    logic [OV_W-1:0]        best;
    nrm_t                   dir;
  } sat_res_t;

  typedef struct packed {
    logic [1:0] count;
    pt_t        c1;
    pt_t        c2;
  } cont_res_t;

endpackage

// File: hdl/rrsc_if.sv
// ----------------------------------------------------------------------------
// rrsc_if
// Valid/ready channels of the collision core: corner input, result, config.
// ----------------------------------------------------------------------------
interface rrsc_in_if;
  logic               valid;
  logic               ready;
  logic               body_select;
  logic [1:0]         corner_index;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [31:0] centroid_x;
  logic signed [31:0] centroid_y;

  modport source(output valid, body_select, corner_index, vertex_x, vertex_y,
                 normal_x, normal_y, centroid_x, centroid_y, input ready);
  modport sink(input valid, body_select, corner_index, vertex_x, vertex_y,
               normal_x, normal_y, centroid_x, centroid_y, output ready);
endinterface

interface rrsc_out_if;
  logic               valid;
  logic               ready;
  logic               collide;
  logic [30:0]        depth;
  logic signed [15:0] direction_x;
  logic signed [15:0] direction_y;
  logic [1:0]         contact_count;
  logic signed [31:0] contact1_x;
  logic signed [31:0] contact1_y;
  logic signed [31:0] contact2_x;
  logic signed [31:0] contact2_y;

  modport source(output valid, collide, depth, direction_x, direction_y,
                 contact_count, contact1_x, contact1_y, contact2_x, contact2_y,
                 input ready);
  modport sink(input valid, collide, depth, direction_x, direction_y,
               contact_count, contact1_x, contact1_y, contact2_x, contact2_y,
               output ready);
endinterface

interface rrsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: hdl/rrsc_mem.sv
// ----------------------------------------------------------------------------
// rrsc_mem
// Corner and normal stores: one write port, registered reads.
// ----------------------------------------------------------------------------
module rrsc_mem import rrsc_pkg::*; #(
  parameter int CORNERS = DEF_CORNERS,
  localparam int AW = $clog2(2 * CORNERS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pt_t           wr_pt,
  input  nrm_t          wr_nrm,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  input  logic [AW-1:0] rn_addr,
  output pt_t           ra_data,
  output pt_t           rb_data,
  output nrm_t          rn_data
);

  pt_t  corner_mem [2*CORNERS];
  nrm_t normal_mem [2*CORNERS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      corner_mem[wr_addr] <= wr_pt;
      normal_mem[wr_addr] <= wr_nrm;
    end
    ra_data <= corner_mem[ra_addr];
    rb_data <= corner_mem[rb_addr];
    rn_data <= normal_mem[rn_addr];
  end

endmodule

// File: hdl/rrsc_sat.sv
// ----------------------------------------------------------------------------
// rrsc_sat
// Separating-axis pass: streams every corner against every normal.
// ----------------------------------------------------------------------------
module rrsc_sat import rrsc_pkg::*; #(
  parameter int CORNERS = DEF_CORNERS,
  localparam int N  = 2 * CORNERS,
  localparam int AW = $clog2(N)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  pt_t           rd_corner,
  input  nrm_t          rd_normal,
  output logic [AW-1:0] corner_addr,
  output logic [AW-1:0] normal_addr,
  output logic          done,
  output sat_res_t      res
);

  logic          issue_r;
  logic [AW-1:0] ax_r, pt_r;

  // stage 1: memory data
  logic v1_r, first1_r, body1_r, last1_r, lax1_r;
  // stage 2: products
  logic v2_r, first2_r, body2_r, last2_r, lax2_r;
  logic signed [PROD_W-1:0] px2_r, py2_r;
  nrm_t n2_r;
  // stage 3: projection
  logic v3_r, first3_r, body3_r, last3_r, lax3_r;
  logic signed [PROJ_W-1:0] proj3_r;
  nrm_t n3_r;
  // stage 4: running extremes, then final extremes of one axis
  logic signed [PROJ_W-1:0] mn_r [2];
  logic signed [PROJ_W-1:0] mx_r [2];
  logic v4_r, lax4_r;
  logic signed [PROJ_W-1:0] mn0_r, mx0_r, mn1_r, mx1_r;
  nrm_t n4_r;
  // stage 5: overlap of the axis
  logic v5_r, lax5_r, sep5_r;
  logic signed [OV_W-1:0] ov5_r;
  nrm_t n5_r;
  // result
  logic have_r, sep_r, done_r;
  logic signed [OV_W-1:0] best_r;
  nrm_t dir_r;

  logic signed [PROD_W-1:0] px_c, py_c;
  logic signed [PROJ_W-1:0] mn_c, mx_c, proj_c;
  logic signed [OV_W-1:0]   o1_c, o2_c;

  assign corner_addr = pt_r;
  assign normal_addr = ax_r;

  assign px_c   = $signed(rd_normal.x) * $signed(rd_corner.x);
  assign py_c   = $signed(rd_normal.y) * $signed(rd_corner.y);
  assign proj_c = {px2_r[PROD_W-1], px2_r} + {py2_r[PROD_W-1], py2_r};
  assign mn_c   = (first3_r || proj3_r < mn_r[body3_r]) ? proj3_r : mn_r[body3_r];
  assign mx_c   = (first3_r || proj3_r > mx_r[body3_r]) ? proj3_r : mx_r[body3_r];
  assign o1_c   = {mx1_r[PROJ_W-1], mx1_r} - {mn0_r[PROJ_W-1], mn0_r};
  assign o2_c   = {mx0_r[PROJ_W-1], mx0_r} - {mn1_r[PROJ_W-1], mn1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      ax_r    <= '0;
      pt_r    <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      have_r  <= 1'b0;
      sep_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      // issue one corner read per cycle, axis by axis
      if (start) begin
        issue_r <= 1'b1;
        ax_r    <= '0;
        pt_r    <= '0;
      end else if (issue_r) begin
        if (pt_r == AW'(N - 1)) begin
          pt_r <= '0;
          if (ax_r == AW'(N - 1)) issue_r <= 1'b0;
          else ax_r <= ax_r + 1'b1;
        end else begin
          pt_r <= pt_r + 1'b1;
        end
      end
      v1_r <= issue_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && last3_r;
      v5_r <= v4_r;
      done_r <= v5_r && lax5_r;
      if (start) begin
        have_r <= 1'b0;
        sep_r  <= 1'b0;
      end else if (v5_r) begin
        if (sep5_r) sep_r <= 1'b1;
        else if (!have_r || ov5_r < best_r) have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (pt_r == '0) || (pt_r == AW'(CORNERS));
    body1_r  <= (pt_r >= AW'(CORNERS));
    last1_r  <= (pt_r == AW'(N - 1));
    lax1_r   <= (ax_r == AW'(N - 1));

    {first2_r, body2_r, last2_r, lax2_r} <= {first1_r, body1_r, last1_r, lax1_r};
    px2_r <= px_c;
    py2_r <= py_c;
    n2_r  <= rd_normal;

    {first3_r, body3_r, last3_r, lax3_r} <= {first2_r, body2_r, last2_r, lax2_r};
    proj3_r <= proj_c;
    n3_r    <= n2_r;

    if (v3_r) begin
      mn_r[body3_r] <= mn_c;
      mx_r[body3_r] <= mx_c;
    end
    // the last corner of an axis always belongs to body B
    mn0_r  <= mn_r[0];
    mx0_r  <= mx_r[0];
    mn1_r  <= mn_c;
    mx1_r  <= mx_c;
    n4_r   <= n3_r;
    lax4_r <= lax3_r;

    sep5_r <= (mx0_r <= mn1_r) || (mx1_r <= mn0_r);
    ov5_r  <= (o1_c < o2_c) ? o1_c : o2_c;
    n5_r   <= n4_r;
    lax5_r <= lax4_r;

    if (v5_r && !sep5_r && (!have_r || ov5_r < best_r)) begin
      best_r <= ov5_r;
      dir_r  <= n5_r;
    end
  end

  assign done     = done_r;
  assign res.sep  = sep_r;
  assign res.best = best_r;
  assign res.dir  = dir_r;

endmodule

// File: hdl/rrsc_contact.sv
// ----------------------------------------------------------------------------
// rrsc_contact
// Contact search: every corner against every edge of the other body.
// ----------------------------------------------------------------------------
module rrsc_contact import rrsc_pkg::*; #(
  parameter int CORNERS       = DEF_CORNERS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int AW = $clog2(2 * CORNERS),
  localparam int CW = $clog2(CORNERS),
  localparam int DT_W = TOL_W + FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TOL_W-1:0] tol,
  input  logic [DT_W-1:0]  dtol,
  input  pt_t              rd_a,
  input  pt_t              rd_b,
  output logic [AW-1:0]    addr_a,
  output logic [AW-1:0]    addr_b,
  output logic             done,
  output cont_res_t        res
);

  typedef enum logic [3:0] {
    C_IDLE, C_RDP, C_RDAB, C_DIFF, C_SHIFT, C_MUL, C_SUM, C_CHK,
    C_DIV, C_CMUL, C_CADD, C_DSQ1, C_DSQ2, C_DSQ3, C_UPD
  } cstate_t;

  cstate_t state_r;
  logic          bsel_r, done_r;
  logic [CW-1:0] i_r, j_r, jn_c;

  pt_t p_r, a_r, b_r, c_r;
  logic signed [DIFF_W-1:0] ab0_r, ab1_r, ap0_r, ap1_r;
  logic signed [RED_W-1:0]  r0_r, r1_r, q0_r, q1_r;
  logic signed [SQ_W-1:0]   pq0_r, pq1_r, rr0_r, rr1_r;
  logic signed [DP_W-1:0]   proj_r;
  logic [SQ_W-1:0]          len_r;
  logic [DEN_W-1:0]         den_r;
  logic [DEN_W:0]           rem_r;
  logic [T_W-1:0]           t_r;
  logic [3:0]               step_r;
  logic signed [CM_W-1:0]   cm0_r, cm1_r;
  logic [RED_W-1:0]         ux_r, uy_r;
  logic                     far_r;
  logic [SQ_W-1:0]          sx_r, sy_r;
  logic [DIST_W-1:0]        d_r, bestd_r;
  logic [1:0]               count_r;
  pt_t                      c1_r, c2_r;

  // combinational helpers
  logic signed [DIFF_W-1:0] ab0_c, ab1_c, ap0_c, ap1_c;
  logic                     wide_c;
  logic signed [DP_W-1:0]   proj_c, len_c;
  logic [4:0]               k_c;
  logic [DEN_W:0]           rem2_c;
  logic                     ge_c;
  logic signed [DIFF_W:0]   cx_c, cy_c;
  logic signed [DIFF_W-1:0] dx_c, dy_c;
  logic [DIFF_W-1:0]        mx_c, my_c;
  logic [DIST_W-1:0]        dd_c;
  logic                     near_d_c, near_c_c;
  logic signed [DIFF_W-1:0] ex_c, ey_c;
  logic [DIFF_W-1:0]        emx_c, emy_c;

  function automatic logic [AW-1:0] caddr(input logic body, input logic [CW-1:0] idx);
    caddr = body ? AW'(CORNERS) + AW'(idx) : AW'(idx);
  endfunction

  function automatic logic [DIFF_W-1:0] umag(input logic signed [DIFF_W-1:0] v);
    umag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic in_rng(input logic signed [DIFF_W-1:0] v);
    in_rng = (v[DIFF_W-1] == v[DIFF_W-2]) && (v[DIFF_W-2] == v[DIFF_W-3]);
  endfunction

  function automatic logic signed [RED_W-1:0] reduce(input logic signed [DIFF_W-1:0] v,
                                                     input logic s);
    reduce = s ? v[DIFF_W-1:2] : v[RED_W-1:0];
  endfunction

  assign jn_c   = (j_r == CW'(CORNERS - 1)) ? '0 : j_r + 1'b1;
  assign addr_a = (state_r == C_RDP) ? caddr(bsel_r, i_r) : caddr(!bsel_r, j_r);
  assign addr_b = caddr(!bsel_r, jn_c);

  assign ab0_c = {rd_b.x[COORD_W-1], rd_b.x} - {rd_a.x[COORD_W-1], rd_a.x};
  assign ab1_c = {rd_b.y[COORD_W-1], rd_b.y} - {rd_a.y[COORD_W-1], rd_a.y};
  assign ap0_c = {p_r.x[COORD_W-1], p_r.x} - {rd_a.x[COORD_W-1], rd_a.x};
  assign ap1_c = {p_r.y[COORD_W-1], p_r.y} - {rd_a.y[COORD_W-1], rd_a.y};
  assign wide_c = !(in_rng(ab0_r) && in_rng(ab1_r) && in_rng(ap0_r) && in_rng(ap1_r));

  assign proj_c = {pq0_r[SQ_W-1], pq0_r} + {pq1_r[SQ_W-1], pq1_r};
  assign len_c  = {rr0_r[SQ_W-1], rr0_r} + {rr1_r[SQ_W-1], rr1_r};

  // shift that brings the edge length below 2^46
  always_comb begin
    k_c = '0;
    for (int n = 0; n < SQ_W - DEN_W; n++) begin
      if (len_r[DEN_W + n]) k_c = 5'(n + 1);
    end
  end

  assign rem2_c = {rem_r[DEN_W-1:0], 1'b0};
  assign ge_c   = rem2_c >= {1'b0, den_r};

  assign cx_c = {{2{a_r.x[COORD_W-1]}}, a_r.x} + cm0_r[CM_W-1:T_W];
  assign cy_c = {{2{a_r.y[COORD_W-1]}}, a_r.y} + cm1_r[CM_W-1:T_W];

  assign dx_c = {p_r.x[COORD_W-1], p_r.x} - {c_r.x[COORD_W-1], c_r.x};
  assign dy_c = {p_r.y[COORD_W-1], p_r.y} - {c_r.y[COORD_W-1], c_r.y};
  assign mx_c = umag(dx_c);
  assign my_c = umag(dy_c);

  assign dd_c     = (d_r > bestd_r) ? d_r - bestd_r : bestd_r - d_r;
  assign near_d_c = dd_c <= DIST_W'(dtol);
  assign ex_c     = {c_r.x[COORD_W-1], c_r.x} - {c1_r.x[COORD_W-1], c1_r.x};
  assign ey_c     = {c_r.y[COORD_W-1], c_r.y} - {c1_r.y[COORD_W-1], c1_r.y};
  assign emx_c    = umag(ex_c);
  assign emy_c    = umag(ey_c);
  assign near_c_c = (emx_c <= DIFF_W'(tol)) && (emy_c <= DIFF_W'(tol));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      bsel_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            bsel_r  <= 1'b0;
            i_r     <= '0;
            j_r     <= '0;
            count_r <= '0;
            state_r <= C_RDP;
          end
        end
        C_RDP:  state_r <= C_RDAB;
        C_RDAB: begin
          p_r     <= rd_a;
          state_r <= C_DIFF;
        end
        C_DIFF: begin
          a_r   <= rd_a;
          b_r   <= rd_b;
          ab0_r <= ab0_c;
          ab1_r <= ab1_c;
          ap0_r <= ap0_c;
          ap1_r <= ap1_c;
          state_r <= C_SHIFT;
        end
        C_SHIFT: begin
          r0_r <= reduce(ab0_r, wide_c);
          r1_r <= reduce(ab1_r, wide_c);
          q0_r <= reduce(ap0_r, wide_c);
          q1_r <= reduce(ap1_r, wide_c);
          state_r <= C_MUL;
        end
        C_MUL: begin
          pq0_r <= r0_r * q0_r;
          pq1_r <= r1_r * q1_r;
          rr0_r <= r0_r * r0_r;
          rr1_r <= r1_r * r1_r;
          state_r <= C_SUM;
        end
        C_SUM: begin
          proj_r  <= proj_c;
          len_r   <= len_c[SQ_W-1:0];
          state_r <= C_CHK;
        end
        C_CHK: begin
          if (len_r == '0 || proj_r[DP_W-1] || proj_r == '0) begin
            c_r     <= a_r;
            state_r <= C_DSQ1;
          end else if (proj_r >= $signed({1'b0, len_r})) begin
            c_r     <= b_r;
            state_r <= C_DSQ1;
          end else if (DEN_W'(proj_r[SQ_W-1:0] >> k_c) == DEN_W'(len_r >> k_c)) begin
            // scaled quotient reaches one: the contact is the edge end
            c_r     <= b_r;
            state_r <= C_DSQ1;
          end else begin
            den_r   <= DEN_W'(len_r >> k_c);
            rem_r   <= {1'b0, DEN_W'(proj_r[SQ_W-1:0] >> k_c)};
            step_r  <= '0;
            state_r <= C_DIV;
          end
        end
        C_DIV: begin
          // one quotient bit per cycle
          rem_r  <= ge_c ? rem2_c - {1'b0, den_r} : rem2_c;
          t_r    <= {t_r[T_W-2:0], ge_c};
          step_r <= step_r + 1'b1;
          if (step_r == 4'(T_W - 1)) state_r <= C_CMUL;
        end
        C_CMUL: begin
          cm0_r   <= ab0_r * $signed({1'b0, t_r});
          cm1_r   <= ab1_r * $signed({1'b0, t_r});
          state_r <= C_CADD;
        end
        C_CADD: begin
          c_r.x   <= cx_c[COORD_W-1:0];
          c_r.y   <= cy_c[COORD_W-1:0];
          state_r <= C_DSQ1;
        end
        C_DSQ1: begin
          far_r   <= mx_c[DIFF_W-1] | mx_c[DIFF_W-2] | my_c[DIFF_W-1] | my_c[DIFF_W-2];
          ux_r    <= mx_c[RED_W-1:0];
          uy_r    <= my_c[RED_W-1:0];
          state_r <= C_DSQ2;
        end
        C_DSQ2: begin
          sx_r    <= ux_r * ux_r;
          sy_r    <= uy_r * uy_r;
          state_r <= C_DSQ3;
        end
        C_DSQ3: begin
          d_r     <= far_r ? '1 : DIST_W'(sx_r) + DIST_W'(sy_r);
          state_r <= C_UPD;
        end
        C_UPD: begin
          if (count_r == '0 || d_r < bestd_r) begin
            bestd_r <= d_r;
            count_r <= 2'd1;
            c1_r    <= c_r;
          end else if (near_d_c && !near_c_c) begin
            c2_r    <= c_r;
            count_r <= 2'd2;
          end
          // advance edge, then corner, then body
          state_r <= C_RDP;
          if (j_r == CW'(CORNERS - 1)) begin
            j_r <= '0;
            if (i_r == CW'(CORNERS - 1)) begin
              i_r <= '0;
              if (bsel_r) begin
                state_r <= C_IDLE;
                done_r  <= 1'b1;
              end else begin
                bsel_r <= 1'b1;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done      = done_r;
  assign res.count = count_r;
  assign res.c1    = c1_r;
  assign res.c2    = c2_r;

endmodule

// File: hdl/rect_rect_sat_collision_core.sv
// ----------------------------------------------------------------------------
// rect_rect_sat_collision_core
// Separating-axis collision test with contact points for two convex quads.
// ----------------------------------------------------------------------------
// Each input item loads one corner of one body (vertex and normal of the edge
// leaving it into a small synchronous corner/normal memory, centroid into a
// register). Items that only load are taken back to back. The item that loads
// the last corner of body B starts the test and the block takes no item until
// the result is in the output register: the separating-axis pass streams one
// memory read per cycle over all 4*CORNERS^2 corner/normal pairs, followed by
// its pipeline drain; if no axis separates, the direction check then forms the
// centroid offset products in S_FLIP1 and sets the sign in S_FLIP2, and the
// contact search visits the 2*CORNERS^2 corner/edge pairs one after another,
// running the 16-step divider only for a pair that does not clamp to an edge
// end. A finished result waits in the output register while new corners are
// loaded. Touching or gapped projections give collide 0 with all other fields
// zero.
// ----------------------------------------------------------------------------
module rect_rect_sat_collision_core import rrsc_pkg::*; #(
  parameter int CORNERS       = DEF_CORNERS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input logic         clk,
  input logic         rst_n,
  rrsc_in_if.sink     in_ch,
  rrsc_out_if.source  out_ch,
  rrsc_cfg_if.sink    cfg_ch
);

  localparam int AW   = $clog2(2 * CORNERS);
  localparam int DT_W = TOL_W + FRACTION_BITS;
  localparam logic [1:0] TRIG_CORNER = 2'((CORNERS - 1) % 4);

  typedef enum logic [2:0] {
    S_IDLE, S_SAT, S_FLIP1, S_FLIP2, S_CONT, S_FIN
  } state_t;

  typedef struct packed {
    logic              collide;
    logic [DEPTH_W-1:0] depth;
    nrm_t              dir;
    logic [1:0]        count;
    pt_t               c1;
    pt_t               c2;
  } out_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  out_t   out_r;
  logic [TOL_W-1:0] tol_r;
  logic [DT_W-1:0]  dtol;
  pt_t    cen_r [2];
  nrm_t   dir_r;
  logic signed [PROJ_W-1:0] fpx_r, fpy_r;
  logic signed [PROJ_W:0]   fsum_c;
  logic signed [DIFF_W-1:0] dcx_c, dcy_c;

  logic          in_acc, trig;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  pt_t           wr_pt, ra_data, rb_data;
  nrm_t          wr_nrm, rn_data;
  logic [AW-1:0] sat_caddr, sat_naddr, cont_a, cont_b, ra_addr;
  logic          sat_done, cont_done;
  sat_res_t      sat_res;
  cont_res_t     cont_res;
  logic          load_out;
  logic [DEPTH_W-1:0] depth_c;

  // input side: take items only while no test is running
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign trig        = in_ch.body_select && (in_ch.corner_index == TRIG_CORNER);

  assign wr_en   = in_acc && (32'(in_ch.corner_index) < CORNERS);
  assign wr_addr = in_ch.body_select ? AW'(CORNERS) + AW'(in_ch.corner_index)
                                     : AW'(in_ch.corner_index);
  assign wr_pt.x  = in_ch.vertex_x;
  assign wr_pt.y  = in_ch.vertex_y;
  assign wr_nrm.x = in_ch.normal_x;
  assign wr_nrm.y = in_ch.normal_y;

  assign cfg_ch.ready = 1'b1;
  assign dtol = {tol_r, {FRACTION_BITS{1'b0}}};

  // port A serves the axis pass, then the contact search
  assign ra_addr = (state_r == S_SAT) ? sat_caddr : cont_a;

  rrsc_mem #(.CORNERS(CORNERS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_pt   (wr_pt),
    .wr_nrm  (wr_nrm),
    .ra_addr (ra_addr),
    .rb_addr (cont_b),
    .rn_addr (sat_naddr),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .rn_data (rn_data)
  );

  rrsc_sat #(.CORNERS(CORNERS)) u_sat (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_acc && trig),
    .rd_corner   (ra_data),
    .rd_normal   (rn_data),
    .corner_addr (sat_caddr),
    .normal_addr (sat_naddr),
    .done        (sat_done),
    .res         (sat_res)
  );

  rrsc_contact #(.CORNERS(CORNERS), .FRACTION_BITS(FRACTION_BITS)) u_contact (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_FLIP2),
    .tol    (tol_r),
    .dtol   (dtol),
    .rd_a   (ra_data),
    .rd_b   (rb_data),
    .addr_a (cont_a),
    .addr_b (cont_b),
    .done   (cont_done),
    .res    (cont_res)
  );

  // centroid offset projected on the chosen axis decides the flip
  assign dcx_c  = {cen_r[1].x[COORD_W-1], cen_r[1].x} - {cen_r[0].x[COORD_W-1], cen_r[0].x};
  assign dcy_c  = {cen_r[1].y[COORD_W-1], cen_r[1].y} - {cen_r[0].y[COORD_W-1], cen_r[0].y};
  assign fsum_c = {fpx_r[PROJ_W-1], fpx_r} + {fpy_r[PROJ_W-1], fpy_r};

  // overlap in Q20.30 down to unsigned Q15.16, saturate
  assign depth_c = (|sat_res.best[OV_W-1:DEPTH_W+NORMAL_FRAC]) ? '1
                 : sat_res.best[DEPTH_W+NORMAL_FRAC-1:NORMAL_FRAC];

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && trig) state_nxt = S_SAT;
      S_SAT:   if (sat_done) state_nxt = sat_res.sep ? S_FIN : S_FLIP1;
      S_FLIP1: state_nxt = S_FLIP2;
      S_FLIP2: state_nxt = S_CONT;
      S_CONT:  if (cont_done) state_nxt = S_FIN;
      S_FIN:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) tol_r <= cfg_ch.data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cen_r[in_ch.body_select].x <= in_ch.centroid_x;
      cen_r[in_ch.body_select].y <= in_ch.centroid_y;
    end
    if (state_r == S_FLIP1) begin
      fpx_r <= dcx_c * sat_res.dir.x;
      fpy_r <= dcy_c * sat_res.dir.y;
    end
    if (state_r == S_FLIP2) begin
      // negate toward B, holding the most negative code at the top
      if (fsum_c[PROJ_W]) begin
        dir_r.x <= (sat_res.dir.x == {1'b1, {(NORM_W-1){1'b0}}}) ? {1'b0, {(NORM_W-1){1'b1}}}
                                                                 : -sat_res.dir.x;
        dir_r.y <= (sat_res.dir.y == {1'b1, {(NORM_W-1){1'b0}}}) ? {1'b0, {(NORM_W-1){1'b1}}}
                                                                 : -sat_res.dir.y;
      end else begin
        dir_r <= sat_res.dir;
      end
    end
    if (load_out) begin
      if (sat_res.sep) begin
        out_r <= '0;
      end else begin
        out_r.collide <= 1'b1;
        out_r.depth   <= depth_c;
        out_r.dir     <= dir_r;
        out_r.count   <= cont_res.count;
        out_r.c1      <= cont_res.c1;
        out_r.c2      <= (cont_res.count == 2'd2) ? cont_res.c2 : '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.collide       = out_r.collide;
  assign out_ch.depth         = out_r.depth;
  assign out_ch.direction_x   = out_r.dir.x;
  assign out_ch.direction_y   = out_r.dir.y;
  assign out_ch.contact_count = out_r.count;
  assign out_ch.contact1_x    = out_r.c1.x;
  assign out_ch.contact1_y    = out_r.c1.y;
  assign out_ch.contact2_x    = out_r.c2.x;
  assign out_ch.contact2_y    = out_r.c2.y;

endmodule

// File: hdl/rrsc_checker.sv
// ----------------------------------------------------------------------------
// rrsc_checker
// Port-level checks of the collision core, bound to the top level.
// ----------------------------------------------------------------------------
module rrsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        collide,
  input logic [30:0] depth,
  input logic [15:0] direction_x,
  input logic [15:0] direction_y,
  input logic [1:0]  contact_count,
  input logic [31:0] contact2_x,
  input logic [31:0] contact2_y
);

  // hold a result item until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // a result only appears at the end of a test, never while loading
  a_out_after_test: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item without a completed test");

  // no overlap: depth, direction and contact count are zero
  a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !collide |-> depth == '0 && direction_x == '0 &&
                              direction_y == '0 && contact_count == '0)
    else $error("separated result carries data");

  // overlap: one or two contacts, second one cleared when single
  a_contacts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && collide |-> (contact_count == 2'd1 && contact2_x == '0 &&
                              contact2_y == '0) || contact_count == 2'd2)
    else $error("bad contact count or stale second contact");

endmodule

bind rect_rect_sat_collision_core rrsc_checker u_rrsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .collide       (out_ch.collide),
  .depth         (out_ch.depth),
  .direction_x   (out_ch.direction_x),
  .direction_y   (out_ch.direction_y),
  .contact_count (out_ch.contact_count),
  .contact2_x    (out_ch.contact2_x),
  .contact2_y    (out_ch.contact2_y)
);
